// File: rtl/tba_pkg.sv
// Shared types and constants for the two-way bridge arbiter.
`default_nettype none
package tba_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_EXT_W    = (ID_BITS > 8) ? ID_BITS : 8;
  localparam int LIMIT_W     = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_LEAVE  = 1'b1;
  localparam logic HD_WEST   = 1'b0;
  localparam logic HD_EAST   = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_DROPPED = 2'd1,
    ST_NO_OCC  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GRANT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic grant;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic exec_result;
    logic grant_ok;
  } sts_t;

  function automatic logic [ID_BITS-1:0] id_from_port(input logic [7:0] v);
    logic [ID_EXT_W-1:0] ext;
    ext = ID_EXT_W'(v);
    return ID_BITS'(ext);
  endfunction

  function automatic logic [7:0] id_to_port(input logic [ID_BITS-1:0] v);
    logic [ID_EXT_W-1:0] ext;
    ext = ID_EXT_W'(v);
    return 8'(ext);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

endpackage
`default_nettype wire

// File: rtl/tba_ctrl.sv
// Control state machine that sequences one beat through load, execute, grant and emit.
`default_nettype none
module tba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire tba_pkg::sts_t sts,
  output tba_pkg::cmd_t      cmd,
  output logic               busy
);
  import tba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.exec_result ? S_IDLE : S_GRANT;
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
        state_nxt = sts.grant_ok ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// File: rtl/tba_datapath.sv
// Queues, run counter, occupancy state and result registers of the arbiter.
`default_nettype none
module tba_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [tba_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  wire logic                         in_opcode,
  input  wire logic                         in_heading,
  input  wire logic [7:0]                   in_requester_id,
  input  wire tba_pkg::cmd_t                cmd,
  output tba_pkg::sts_t                     sts,
  output logic                              out_valid,
  output logic [7:0]                        out_granted_id,
  output logic                              out_granted_heading,
  output logic [1:0]                        out_status
);
  import tba_pkg::*;

  logic [ID_BITS-1:0] west_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0] east_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0] west_q_r, east_q_r;

  logic               op_r, hd_r;
  logic [ID_BITS-1:0] id_r;

  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [FILL_W-1:0]  west_fill_r, west_fill_nxt, east_fill_r, east_fill_nxt;
  logic [PTR_W-1:0]   west_rd_r, west_rd_nxt, east_rd_r, east_rd_nxt;
  logic [PTR_W-1:0]   west_wr_r, west_wr_nxt, east_wr_r, east_wr_nxt;
  logic [LIMIT_W-1:0] run_r, run_nxt;
  logic               res_busy_r, res_busy_nxt;
  logic               occ_r, occ_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_id_r, out_id_nxt;
  logic               out_hd_r, out_hd_nxt;
  logic [1:0]         out_st_r, out_st_nxt;

  logic west_full, east_full, west_we, east_we, pick_east;

  assign west_full = (west_fill_r == FILL_W'(QUEUE_DEPTH));
  assign east_full = (east_fill_r == FILL_W'(QUEUE_DEPTH));
  assign pick_east = (east_fill_r != '0) && ((run_r < limit_r) || (west_fill_r == '0));

  assign sts.exec_result = (op_r == OP_ARRIVE) ? ((hd_r == HD_WEST) ? west_full : east_full)
                                               : !res_busy_r;
  assign sts.grant_ok    = !res_busy_r && ((west_fill_r != '0) || (east_fill_r != '0));

  assign west_we = cmd.exec && (op_r == OP_ARRIVE) && (hd_r == HD_WEST) && !west_full;
  assign east_we = cmd.exec && (op_r == OP_ARRIVE) && (hd_r == HD_EAST) && !east_full;

  always_ff @(posedge clk) begin
    if (west_we) begin
      west_mem[west_wr_r] <= id_r;
    end
    if (east_we) begin
      east_mem[east_wr_r] <= id_r;
    end
    west_q_r <= west_mem[west_rd_r];
    east_q_r <= east_mem[east_rd_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      hd_r <= in_heading;
      id_r <= id_from_port(in_requester_id);
    end
    out_id_r <= out_id_nxt;
    out_hd_r <= out_hd_nxt;
    out_st_r <= out_st_nxt;
  end

  always_comb begin
    limit_nxt     = cfg_we ? cfg_wdata : limit_r;
    west_fill_nxt = west_fill_r;
    east_fill_nxt = east_fill_r;
    west_rd_nxt   = west_rd_r;
    east_rd_nxt   = east_rd_r;
    west_wr_nxt   = west_wr_r;
    east_wr_nxt   = east_wr_r;
    run_nxt       = run_r;
    res_busy_nxt  = res_busy_r;
    occ_nxt       = occ_r;
    out_valid_nxt = 1'b0;
    out_id_nxt    = out_id_r;
    out_hd_nxt    = out_hd_r;
    out_st_nxt    = out_st_r;

    if (cmd.exec) begin
      if (sts.exec_result) begin
        out_valid_nxt = 1'b1;
        if (op_r == OP_ARRIVE) begin
          out_id_nxt = id_to_port(id_r);
          out_hd_nxt = hd_r;
          out_st_nxt = ST_DROPPED;
        end else begin
          out_id_nxt = '0;
          out_hd_nxt = HD_WEST;
          out_st_nxt = ST_NO_OCC;
        end
      end else if (op_r == OP_ARRIVE) begin
        if (hd_r == HD_WEST) begin
          if (west_fill_r == '0) begin
            run_nxt = '0;
          end
          west_wr_nxt   = ptr_inc(west_wr_r);
          west_fill_nxt = FILL_W'(west_fill_r + 1'b1);
        end else begin
          east_wr_nxt   = ptr_inc(east_wr_r);
          east_fill_nxt = FILL_W'(east_fill_r + 1'b1);
        end
      end else begin
        if (occ_r == HD_WEST) begin
          if (west_fill_r != '0) begin
            west_rd_nxt   = ptr_inc(west_rd_r);
            west_fill_nxt = FILL_W'(west_fill_r - 1'b1);
          end
          run_nxt = '0;
        end else begin
          if (east_fill_r != '0) begin
            east_rd_nxt   = ptr_inc(east_rd_r);
            east_fill_nxt = FILL_W'(east_fill_r - 1'b1);
          end
          if (run_r < limit_r) begin
            run_nxt = LIMIT_W'(run_r + 1'b1);
          end
        end
        res_busy_nxt = 1'b0;
      end
    end

    if (cmd.grant && sts.grant_ok) begin
      res_busy_nxt = 1'b1;
      occ_nxt      = pick_east ? HD_EAST : HD_WEST;
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = id_to_port((occ_r == HD_EAST) ? east_q_r : west_q_r);
      out_hd_nxt    = occ_r;
      out_st_nxt    = ST_GRANTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      west_fill_r <= '0;
      east_fill_r <= '0;
      west_rd_r   <= '0;
      east_rd_r   <= '0;
      west_wr_r   <= '0;
      east_wr_r   <= '0;
      run_r       <= '0;
      res_busy_r  <= 1'b0;
      occ_r       <= HD_WEST;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      west_fill_r <= west_fill_nxt;
      east_fill_r <= east_fill_nxt;
      west_rd_r   <= west_rd_nxt;
      east_rd_r   <= east_rd_nxt;
      west_wr_r   <= west_wr_nxt;
      east_wr_r   <= east_wr_nxt;
      run_r       <= run_nxt;
      res_busy_r  <= res_busy_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_id      = out_id_r;
  assign out_granted_heading = out_hd_r;
  assign out_status          = out_st_r;

endmodule
`default_nettype wire

// File: rtl/two_way_bridge_arbiter.sv
// Top level of the two-way bridge arbiter: controller plus datapath.
//
//   Channel  Ports                                            Handshake
//   input    in_opcode, in_heading, in_requester_id           start & !busy
//   result   out_granted_id, out_granted_heading, out_status  out_valid, one cycle
//   config   cfg_wdata                                        cfg_we
//
// An accepted beat ends in execute on a drop or a leave with no occupant; else it
// moves to grant, and to emit when it ends in a grant, which reads the registered
// output of the queue memories. A beat with no grant gives no result. A result is
// valid in the first cycle that busy is low again. Reset is synchronous and empties
// both queues. The receiver cannot stall; out_valid lasts exactly one cycle.
`default_nettype none
module two_way_bridge_arbiter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_opcode,
  input  wire logic                        in_heading,
  input  wire logic [7:0]                  in_requester_id,
  output logic                             out_valid,
  output logic [7:0]                       out_granted_id,
  output logic                             out_granted_heading,
  output logic [1:0]                       out_status,
  input  wire logic                        cfg_we,
  input  wire logic [tba_pkg::LIMIT_W-1:0] cfg_wdata
);
  import tba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tba_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_opcode           (in_opcode),
    .in_heading          (in_heading),
    .in_requester_id     (in_requester_id),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_granted_id      (out_granted_id),
    .out_granted_heading (out_granted_heading),
    .out_status          (out_status)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("Accepted beat did not raise busy.");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("Result strobe without a beat in progress.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_GRANTED || out_status == ST_DROPPED ||
                   out_status == ST_NO_OCC))
    else $error("Result carries an undefined status code.");

  a_no_occ_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NO_OCC |-> out_granted_id == 8'd0 && !out_granted_heading)
    else $error("Leave without occupant reports nonzero fields.");

endmodule
`default_nettype wire

// File: test/tb_two_way_bridge_arbiter.sv
// Testbench for the two-way bridge arbiter: queued beats with a checked grant predictor.
`default_nettype none
module tb_two_way_bridge_arbiter;
  timeunit 1ns;
  timeprecision 1ps;

  import tba_pkg::*;

  typedef struct packed {
    logic       op;
    logic       hd;
    logic [7:0] id;
  } bridge_req_t;

  typedef struct packed {
    logic [7:0] id;
    logic       hd;
    status_t    st;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = OP_ARRIVE;
  logic in_heading = HD_WEST;
  logic [7:0] in_requester_id = 8'h00;
  logic out_valid;
  logic [7:0] out_granted_id;
  logic out_granted_heading;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = LIMIT_RESET;

  bridge_req_t beats_to_send[$];
  bridge_req_t on_port;
  grant_t awaited_grants[$];
  int hold_cycles = 0;
  bit steady = 1'b0;
  int mismatches = 0;

  logic [ID_BITS-1:0] west_ids[$];
  logic [ID_BITS-1:0] east_ids[$];
  logic held = 1'b0;
  logic holder_hd = HD_WEST;
  logic [LIMIT_W-1:0] east_run = '0;
  logic [LIMIT_W-1:0] run_limit = LIMIT_RESET;

  two_way_bridge_arbiter dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_heading          (in_heading),
    .in_requester_id     (in_requester_id),
    .out_valid           (out_valid),
    .out_granted_id      (out_granted_id),
    .out_granted_heading (out_granted_heading),
    .out_status          (out_status),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void grant_if_free();
    logic take_east;
    grant_t g;
    if (held || (west_ids.size() == 0 && east_ids.size() == 0)) return;
    take_east = (east_ids.size() != 0) && (east_run < run_limit || west_ids.size() == 0);
    held = 1'b1;
    holder_hd = take_east ? HD_EAST : HD_WEST;
    g.id = take_east ? 8'(east_ids[0]) : 8'(west_ids[0]);
    g.hd = holder_hd;
    g.st = ST_GRANTED;
    awaited_grants.push_back(g);
  endfunction

  function automatic void predict_beat(input bridge_req_t r);
    grant_t g;
    if (r.op == OP_ARRIVE) begin
      if ((r.hd == HD_WEST && west_ids.size() >= QUEUE_DEPTH) ||
          (r.hd == HD_EAST && east_ids.size() >= QUEUE_DEPTH)) begin
        g.id = r.id;
        g.hd = r.hd;
        g.st = ST_DROPPED;
        awaited_grants.push_back(g);
        return;
      end
      if (r.hd == HD_WEST) begin
        if (west_ids.size() == 0) east_run = '0;
        west_ids.push_back(ID_BITS'(r.id));
      end else begin
        east_ids.push_back(ID_BITS'(r.id));
      end
      grant_if_free();
    end else begin
      if (!held) begin
        g.id = 8'h00;
        g.hd = HD_WEST;
        g.st = ST_NO_OCC;
        awaited_grants.push_back(g);
        return;
      end
      if (holder_hd == HD_WEST) begin
        if (west_ids.size() != 0) void'(west_ids.pop_front());
        east_run = '0;
      end else begin
        if (east_ids.size() != 0) void'(east_ids.pop_front());
        if (east_run < run_limit) east_run = east_run + 1'b1;
      end
      held = 1'b0;
      grant_if_free();
    end
  endfunction

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_beat(on_port);
      if (!start || !busy) begin
        if (hold_cycles > 0) begin
          hold_cycles <= hold_cycles - 1;
          start <= 1'b0;
        end else if (beats_to_send.size() != 0 && !steady && $urandom_range(0, 5) == 0) begin
          hold_cycles <= $urandom_range(0, 9);
          start <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          on_port = beats_to_send.pop_front();
          in_opcode <= on_port.op;
          in_heading <= on_port.hd;
          in_requester_id <= on_port.id;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid) begin
      if (awaited_grants.size() == 0) begin
        note_mismatch($sformatf("unexpected beat id=%02h hd=%0b st=%0d",
                                out_granted_id, out_granted_heading, out_status));
      end else begin
        want = awaited_grants.pop_front();
        if (out_granted_id !== want.id)
          note_mismatch($sformatf("granted_id %02h, expected %02h", out_granted_id, want.id));
        if (out_granted_heading !== want.hd)
          note_mismatch($sformatf("granted_heading %0b, expected %0b",
                                  out_granted_heading, want.hd));
        if (out_status !== want.st)
          note_mismatch($sformatf("status %0d, expected %0d", out_status, want.st));
      end
    end
  end

  task automatic queue_beat(input logic op, input logic hd, input logic [7:0] id);
    bridge_req_t r;
    r.op = op;
    r.hd = hd;
    r.id = id;
    beats_to_send.push_back(r);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || start || awaited_grants.size() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    run_limit = v;
  endtask

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [LIMIT_W-1:0] lim;
    int leave_pct;
    int east_pct;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_beat(OP_LEAVE, HD_EAST, 8'hC3);
    queue_beat(OP_ARRIVE, HD_WEST, 8'h00);
    queue_beat(OP_LEAVE, HD_WEST, 8'h00);
    queue_beat(OP_ARRIVE, HD_EAST, 8'hFF);
    queue_beat(OP_ARRIVE, HD_WEST, 8'hAA);
    queue_beat(OP_ARRIVE, HD_EAST, 8'h55);
    queue_beat(OP_ARRIVE, HD_EAST, 8'h01);
    queue_beat(OP_ARRIVE, HD_EAST, 8'h80);
    queue_beat(OP_LEAVE, HD_WEST, 8'hFF);
    queue_beat(OP_LEAVE, HD_EAST, 8'h00);
    queue_beat(OP_LEAVE, HD_WEST, 8'h7E);
    queue_beat(OP_ARRIVE, HD_WEST, 8'h33);
    queue_beat(OP_LEAVE, HD_WEST, 8'h00);
    settle();
    set_limit(4'd15);
    queue_beat(OP_ARRIVE, HD_EAST, 8'h11);
    queue_beat(OP_ARRIVE, HD_EAST, 8'h22);
    queue_beat(OP_ARRIVE, HD_EAST, 8'h44);
    queue_beat(OP_LEAVE, HD_EAST, 8'h00);
    queue_beat(OP_LEAVE, HD_EAST, 8'h00);
    settle();
    set_limit(4'd1);
    queue_beat(OP_LEAVE, HD_EAST, 8'h00);
    queue_beat(OP_LEAVE, HD_WEST, 8'h00);
    queue_beat(OP_LEAVE, HD_EAST, 8'h00);
    settle();
    set_limit(4'd0);
    queue_beat(OP_ARRIVE, HD_EAST, 8'h5A);
    queue_beat(OP_ARRIVE, HD_EAST, 8'hA5);
    queue_beat(OP_ARRIVE, HD_WEST, 8'h0F);
    queue_beat(OP_LEAVE, HD_EAST, 8'h00);
    queue_beat(OP_LEAVE, HD_WEST, 8'h00);
    queue_beat(OP_LEAVE, HD_EAST, 8'h00);

    for (int ph = 0; ph < 11; ph++) begin
      settle();
      case (ph)
        0: lim = 4'd15;
        1: lim = 4'd1;
        2: lim = 4'd0;
        default: lim = LIMIT_W'($urandom_range(0, 15));
      endcase
      set_limit(lim);
      leave_pct = 10 + 20 * $urandom_range(0, 3);
      east_pct = 10 + 40 * $urandom_range(0, 2);
      steady = (ph == 10);
      for (int n = 0; n < 100; n++) begin
        queue_beat(($urandom_range(0, 99) < leave_pct) ? OP_LEAVE : OP_ARRIVE,
                   ($urandom_range(0, 99) < east_pct) ? HD_EAST : HD_WEST,
                   8'($urandom_range(0, 255)));
      end
    end
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
